// ----- design/vtm_pkg.sv -----
// package for the virtual timer multiplexer: slot count, codes and shared types
// no dependencies
package vtm_pkg;
    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [31:0] MAX_PERIOD_RESET = 32'd5368709;
    localparam logic [31:0] SAT_MAX = 32'hffffffff;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_START   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  slot_index;
        logic        repeat_mode;
        logic [31:0] duration_us;
    } req_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [4:0] result_slot;
        logic       alloc_failed;
        logic       last_result;
    } res_t;
endpackage

// ----- design/vtm_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module vtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- design/vtm_front.sv -----
// front end: accepts requests into a two-entry queue
// depends on vtm_pkg
module vtm_front import vtm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  req_t in_req,
    output logic q_valid,
    input  logic q_ready,
    output req_t q_req
);
    req_t       buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    wire push = in_valid && in_ready;
    wire pop  = q_valid && q_ready;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = buf_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_req;
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'd2) else $error("queue overfill");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid while empty");
    a_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && cnt_reg == 2'd0) |=> cnt_reg == 2'd1)
        else $error("push lost");
endmodule

// ----- design/vtm_back.sv -----
// back end: executes requests, walks slots on a match, drives result register
// depends on vtm_pkg and vtm_ram
module vtm_back import vtm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] max_period,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_req,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_UPD  = 5'b00100,
        S_EMIT = 5'b01000,
        S_FIN  = 5'b10000
    } state_t;

    state_t state_reg;
    logic [NUM_SLOTS-1:0] act_reg, run_reg, cont_reg;
    logic [31:0] count_reg, period_reg, elapsed_reg, best_reg;
    logic        srun_reg, found_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic        ov_reg;
    res_t        res_reg;
    logic        res_valid_reg;
    logic        res_load;
    // pending timeout held back one slot so that last_result is known
    logic        pend_reg;
    logic [SLOT_W-1:0] pend_slot_reg;

    logic        rem_we, rel_we;
    logic [SLOT_W-1:0] ram_addr;
    logic [31:0] rem_wdata, rem_rdata, rel_rdata;

    vtm_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_rem (
        .aclk(aclk), .we(rem_we), .addr(ram_addr), .wdata(rem_wdata), .rdata(rem_rdata));
    vtm_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_rel (
        .aclk(aclk), .we(rel_we), .addr(ram_addr), .wdata(q_req.duration_us),
        .rdata(rel_rdata));

    wire out_free = !res_valid_reg || m_ready;
    assign m_valid = res_valid_reg;
    assign m_res   = res_reg;

    // start path values
    wire         st_ok  = ({27'd0, q_req.slot_index} < NUM_SLOTS);
    wire [32:0]  st_sum = {1'b0, q_req.duration_us} + {1'b0, count_reg};
    wire [31:0]  st_r   = st_sum[32] ? SAT_MAX : st_sum[31:0];
    wire [31:0]  st_rem = srun_reg ? st_r : q_req.duration_us;
    wire [31:0]  cnt_inc = (count_reg == SAT_MAX) ? count_reg : count_reg + 32'd1;

    // first free slot
    logic            free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    // slot update during the walk
    wire         live  = act_reg[idx_reg] && run_reg[idx_reg];
    wire [31:0]  sub   = (elapsed_reg > rem_rdata) ? 32'd0 : rem_rdata - elapsed_reg;
    wire         expd  = live && (sub == 32'd0);
    wire [31:0]  newrem = (expd && cont_reg[idx_reg]) ? rel_rdata : sub;
    wire         stillrun = live && !(expd && !cont_reg[idx_reg]);
    wire         last_idx = (idx_reg == SLOT_W'(NUM_SLOTS - 1));

    wire idle_take  = (state_reg == S_IDLE) && q_valid && out_free;
    wire take_start = idle_take && q_req.operation == OP_START;
    assign ram_addr = (state_reg == S_IDLE) ? q_req.slot_index[SLOT_W-1:0] : idx_reg;
    assign rem_we   = (take_start && st_ok) || (state_reg == S_UPD && live);
    assign rel_we   = take_start && st_ok;
    assign rem_wdata = (state_reg == S_IDLE) ? st_rem : newrem;

    // a new result enters the output register this cycle
    assign res_load = (idle_take && (q_req.operation inside {OP_ALLOC, OP_START}))
                      || (state_reg == S_EMIT && ov_reg && pend_reg && out_free)
                      || (state_reg == S_FIN && out_free && pend_reg);

    always_comb begin
        q_ready = 1'b0;
        if (state_reg == S_IDLE && out_free) begin
            q_ready = q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            act_reg <= '0; run_reg <= '0; cont_reg <= '0;
            count_reg <= '0; period_reg <= '0; srun_reg <= 1'b0;
            res_valid_reg <= 1'b0; pend_reg <= 1'b0;
            idx_reg <= '0; found_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid && out_free) begin
                        case (q_req.operation)
                            OP_ALLOC: begin
                                if (free_any) begin
                                    act_reg[free_idx] <= 1'b1;
                                    run_reg[free_idx] <= 1'b0;
                                end
                                res_reg <= '{KIND_ALLOC, free_idx, !free_any, 1'b1};
                            end
                            OP_START: begin
                                res_reg <= '{KIND_START, q_req.slot_index, 1'b0, 1'b1};
                                if (st_ok) begin
                                    cont_reg[q_req.slot_index[SLOT_W-1:0]] <= q_req.repeat_mode;
                                    run_reg[q_req.slot_index[SLOT_W-1:0]] <= 1'b1;
                                    if (srun_reg) begin
                                        if (st_r < period_reg)
                                            period_reg <= (st_r > max_period) ? max_period : st_r;
                                    end else begin
                                        count_reg <= '0;
                                        period_reg <= (q_req.duration_us > max_period)
                                                      ? max_period : q_req.duration_us;
                                        srun_reg <= 1'b1;
                                    end
                                end
                            end
                            OP_TICK: begin
                                if (srun_reg) begin
                                    if (cnt_inc < period_reg) begin
                                        count_reg <= cnt_inc;
                                    end else begin
                                        elapsed_reg <= cnt_inc;
                                        count_reg <= '0;
                                        idx_reg <= '0;
                                        found_reg <= 1'b0;
                                        best_reg <= '0;
                                        pend_reg <= 1'b0;
                                        state_reg <= S_RD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: state_reg <= S_UPD;
                S_UPD: begin
                    run_reg[idx_reg] <= stillrun ? 1'b1 : (live ? 1'b0 : run_reg[idx_reg]);
                    // only active slots still running after the update set the next period
                    if (stillrun && (!found_reg || newrem < best_reg)) begin
                        best_reg <= newrem;
                        found_reg <= 1'b1;
                    end
                    ov_reg <= expd;
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // emit held timeout when a newer one arrives
                    if (ov_reg && pend_reg) begin
                        if (out_free) begin
                            res_reg <= '{KIND_TIMEOUT, pend_slot_reg, 1'b0, 1'b0};
                            pend_slot_reg <= idx_reg;
                            ov_reg <= 1'b0;
                        end
                    end else begin
                        if (ov_reg) begin
                            pend_reg <= 1'b1;
                            pend_slot_reg <= idx_reg;
                        end
                        if (last_idx) begin
                            state_reg <= S_FIN;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        if (pend_reg) begin
                            res_reg <= '{KIND_TIMEOUT, pend_slot_reg, 1'b0, 1'b1};
                        end
                        if (!found_reg) begin
                            srun_reg <= 1'b0;
                            period_reg <= '0;
                        end else begin
                            period_reg <= (best_reg > max_period) ? max_period : best_reg;
                        end
                        pend_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_qr: assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> state_reg == S_IDLE) else $error("request taken while busy");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_res)) else $error("result dropped");
    a_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        !srun_reg |-> period_reg == 32'd0 || state_reg != S_IDLE || count_reg == 32'd0)
        else $error("stopped counter moving");
endmodule

// ----- design/virtual_timer_multiplexer.sv -----
// virtual timer multiplexer: front queue, back executor, config register
// path: alloc and start answers pass the queue and the result register; a tick
// at a match walks all slots (read, update, emit) before the next request
// throughput: one request per cycle while m_tready is high, except match ticks
// reset: aresetn synchronous active low clears all slot flags, the shared counter
// and queue; remaining and reload values live in ram and are rewritten by start
module virtual_timer_multiplexer import vtm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: operation[1:0], slot_index[6:2], repeat_mode[7], duration_us[39:8]
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: result_kind[1:0], result_slot[6:2], alloc_failed[7]
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    logic [31:0] max_period_reg;
    req_t        in_req, q_req;
    logic        q_valid, q_ready;
    res_t        res;

    // configuration register, always writable
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_period_reg <= MAX_PERIOD_RESET;
        end else if (cfg_valid) begin
            max_period_reg <= cfg_data;
        end
    end

    assign in_req = '{s_tdata[1:0], s_tdata[6:2], s_tdata[7], s_tdata[39:8]};

    // request queue between front and back
    vtm_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

    // executor with slot walk and result register
    vtm_back u_back (
        .aclk(aclk), .aresetn(aresetn), .max_period(max_period_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_res(res));

    assign m_tdata = {res.alloc_failed, res.result_slot, res.result_kind};
    assign m_tlast = res.last_result;
endmodule
